### hdl/u2gb_pkg.sv
// shared types and constants for the utf-8 to gb2312 transcoder
package u2gb_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TABLE_CW    = TABLE_AW + 1;
    localparam int TABLE_DW    = 32;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    localparam int ENTRIES_W   = 14;
    localparam int CAPACITY_W  = 16;
    localparam int SLOT_W      = 13;
    localparam int CODE_W      = 16;
    localparam int POINT_W     = 21;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0]  REG_TABLE_ENTRIES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  REG_OUTPUT_CAPACITY = 1'b1;
    localparam logic [ENTRIES_W-1:0]  ENTRIES_RESET       = '0;
    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET      = 16'd256;
    localparam logic [7:0]            QUESTION_MARK       = 8'h3F;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ONE,
        OP_LOOKUP,
        OP_TERM
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] key;
        logic [CODE_W-1:0] gb;
    } cmd_t;

    typedef struct packed {
        logic [ENTRIES_W-1:0]  table_entries;
        logic [CAPACITY_W-1:0] output_capacity;
    } cfg_t;

endpackage

### hdl/u2gb_ram.sv
// generic single-write single-read ram with registered read data
module u2gb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/u2gb_front.sv
// front end: accepts items, decodes utf-8 and queues commands
module u2gb_front
    import u2gb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [7:0]        text_byte,
    input  logic [SLOT_W-1:0] entry_slot,
    input  logic [CODE_W-1:0] entry_code_point,
    input  logic [CODE_W-1:0] entry_gb_code,
    input  logic              full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [POINT_W-1:0] point_reg;
    logic [POINT_W-1:0] point_next;
    logic [1:0]         pending_reg;
    logic [1:0]         pending_next;
    logic [POINT_W-1:0] acc;
    logic               lead;
    logic               accept;

    function automatic cmd_t classify(input logic [POINT_W-1:0] p);
        cmd_t c;
        c = '0;
        if (p < POINT_W'(8'h80))
        begin
            c.op  = OP_ONE;
            c.key = {8'h00, p[7:0]};
        end
        else if (p > POINT_W'(16'hFFFF))
        begin
            c.op  = OP_ONE;
            c.key = {8'h00, QUESTION_MARK};
        end
        else
        begin
            c.op  = OP_LOOKUP;
            c.key = p[CODE_W-1:0];
        end
        return c;
    endfunction

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign acc      = {point_reg[POINT_W-7:0], text_byte[5:0]};

    always_comb
    begin
        point_next   = point_reg;
        pending_next = pending_reg;
        push         = 1'b0;
        push_cmd     = '0;
        lead         = 1'b0;
        if (accept)
        begin
            if (!kind)
            begin
                push          = 1'b1;
                push_cmd.op   = OP_WRITE;
                push_cmd.slot = entry_slot;
                push_cmd.key  = entry_code_point;
                push_cmd.gb   = entry_gb_code;
            end
            else if (text_byte == 8'h00)
            begin
                push         = 1'b1;
                push_cmd.op  = OP_TERM;
                point_next   = '0;
                pending_next = '0;
            end
            else
            begin
                lead = 1'b1;
                if (pending_reg != 2'd0)
                begin
                    if ((text_byte & 8'hC0) == 8'h80)
                    begin
                        lead         = 1'b0;
                        pending_next = pending_reg - 2'd1;
                        if (pending_reg == 2'd1)
                        begin
                            point_next = '0;
                            push       = 1'b1;
                            push_cmd   = classify(acc);
                        end
                        else
                        begin
                            point_next = acc;
                        end
                    end
                    else
                    begin
                        // broken sequence, reparse this byte as a lead
                        point_next   = '0;
                        pending_next = '0;
                    end
                end
                if (lead)
                begin
                    if (text_byte < 8'h80)
                    begin
                        push     = 1'b1;
                        push_cmd = classify(POINT_W'(text_byte));
                    end
                    else if ((text_byte & 8'hE0) == 8'hC0)
                    begin
                        point_next   = POINT_W'(text_byte & 8'h1F);
                        pending_next = 2'd1;
                    end
                    else if ((text_byte & 8'hF0) == 8'hE0)
                    begin
                        point_next   = POINT_W'(text_byte & 8'h0F);
                        pending_next = 2'd2;
                    end
                    else if ((text_byte & 8'hF8) == 8'hF0)
                    begin
                        point_next   = POINT_W'(text_byte & 8'h07);
                        pending_next = 2'd3;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            point_reg   <= point_next;
            pending_reg <= pending_next;
        end
    end

endmodule

### hdl/u2gb_fifo.sv
// short command queue between front and back end
module u2gb_fifo
    import u2gb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t               slots_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + FIFO_CW'(1);
                2'b01:   count_reg <= count_reg - FIFO_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### hdl/u2gb_back.sv
// back end: table writes, binary search, capacity rule and output register
module u2gb_back
    import u2gb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  empty,
    input  cmd_t                  pop_cmd,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  is_terminator,
    output logic [CAPACITY_W-1:0] out_length
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ONE,
        S_SEARCH,
        S_CMP,
        S_TWO,
        S_LO,
        S_TERM
    } state_t;

    state_t                state_reg,  state_next;
    cmd_t                  cmd_reg,    cmd_next;
    logic [TABLE_CW-1:0]   lo_reg,     lo_next;
    logic [TABLE_CW-1:0]   hi_reg,     hi_next;
    logic [TABLE_CW-1:0]   mid_reg,    mid_next;
    logic [7:0]            byte_reg,   byte_next;
    logic [CODE_W-1:0]     gb_reg,     gb_next;
    logic [CAPACITY_W-1:0] count_reg,  count_next;
    logic                  stop_reg,   stop_next;
    logic                  ovalid_reg, ovalid_next;
    logic [7:0]            obyte_reg,  obyte_next;
    logic                  oterm_reg,  oterm_next;
    logic [CAPACITY_W-1:0] olen_reg,   olen_next;

    logic                  out_free;
    logic [TABLE_CW-1:0]   mid;
    logic                  ram_we;
    logic [TABLE_DW-1:0]   ram_rdata;
    logic [CODE_W-1:0]     ram_key;
    logic                  fits_one;
    logic                  fits_two;

    u2gb_ram #(
        .WIDTH (TABLE_DW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (TABLE_AW'(cmd_reg.slot)),
        .wdata ({cmd_reg.key, cmd_reg.gb}),
        .raddr (mid[TABLE_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free = !ovalid_reg || out_ready;
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ram_key  = ram_rdata[TABLE_DW-1:CODE_W];
    assign fits_one = ({1'b0, count_reg} + 17'd2) <= {1'b0, cfg.output_capacity};
    assign fits_two = ({1'b0, count_reg} + 17'd3) <= {1'b0, cfg.output_capacity};

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        byte_next   = byte_reg;
        gb_next     = gb_reg;
        count_next  = count_reg;
        stop_next   = stop_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        oterm_next  = oterm_reg;
        olen_next   = olen_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_WRITE:
                    begin
                        ram_we     = (32'(cmd_reg.slot) < TABLE_DEPTH);
                        state_next = S_IDLE;
                    end
                    OP_ONE:
                    begin
                        byte_next  = cmd_reg.key[7:0];
                        state_next = S_ONE;
                    end
                    OP_LOOKUP:
                    begin
                        if (stop_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            lo_next = '0;
                            if (32'(cfg.table_entries) > TABLE_DEPTH)
                            begin
                                hi_next = TABLE_CW'(TABLE_DEPTH);
                            end
                            else
                            begin
                                hi_next = TABLE_CW'(cfg.table_entries);
                            end
                            state_next = S_SEARCH;
                        end
                    end
                    OP_TERM:
                    begin
                        state_next = S_TERM;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                // table read issued here, data compared in the next cycle
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    byte_next  = QUESTION_MARK;
                    state_next = S_ONE;
                end
            end
            S_CMP:
            begin
                if (ram_key == cmd_reg.key)
                begin
                    if (ram_rdata[CODE_W-1:0] != '0)
                    begin
                        gb_next    = ram_rdata[CODE_W-1:0];
                        state_next = S_TWO;
                    end
                    else
                    begin
                        byte_next  = QUESTION_MARK;
                        state_next = S_ONE;
                    end
                end
                else if (ram_key < cmd_reg.key)
                begin
                    lo_next    = mid_reg + TABLE_CW'(1);
                    state_next = S_SEARCH;
                end
                else
                begin
                    hi_next    = mid_reg;
                    state_next = S_SEARCH;
                end
            end
            S_ONE:
            begin
                if (stop_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!fits_one)
                begin
                    stop_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = byte_reg;
                    oterm_next  = 1'b0;
                    olen_next   = '0;
                    count_next  = count_reg + CAPACITY_W'(1);
                    state_next  = S_IDLE;
                end
            end
            S_TWO:
            begin
                if (!fits_two)
                begin
                    stop_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = gb_reg[CODE_W-1:8];
                    oterm_next  = 1'b0;
                    olen_next   = '0;
                    count_next  = count_reg + CAPACITY_W'(1);
                    state_next  = S_LO;
                end
            end
            S_LO:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = gb_reg[7:0];
                    oterm_next  = 1'b0;
                    olen_next   = '0;
                    count_next  = count_reg + CAPACITY_W'(1);
                    state_next  = S_IDLE;
                end
            end
            S_TERM:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = 8'h00;
                    oterm_next  = 1'b1;
                    olen_next   = count_reg;
                    count_next  = '0;
                    stop_next   = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            byte_reg   <= '0;
            gb_reg     <= '0;
            count_reg  <= '0;
            stop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            obyte_reg  <= '0;
            oterm_reg  <= 1'b0;
            olen_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            mid_reg    <= mid_next;
            byte_reg   <= byte_next;
            gb_reg     <= gb_next;
            count_reg  <= count_next;
            stop_reg   <= stop_next;
            ovalid_reg <= ovalid_next;
            obyte_reg  <= obyte_next;
            oterm_reg  <= oterm_next;
            olen_reg   <= olen_next;
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_byte      = obyte_reg;
    assign is_terminator = oterm_reg;
    assign out_length    = olen_reg;

`ifndef SYNTH
    a_len_only_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !oterm_reg) |-> (olen_reg == '0))
        else $error("length on a non-terminator result");
    a_term_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oterm_reg) |-> (obyte_reg == 8'h00))
        else $error("terminator byte not zero");
    a_cmp_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_SEARCH))
        else $error("compare without a table read");
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

### hdl/utf8_to_gb2312_transcoder.sv
// top level of the utf-8 to gb2312 transcoder: config registers and the front/queue/back chain
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------------
//  input   | in_valid / in_ready   | kind, text_byte, entry_slot, entry_code_point, entry_gb_code
//  output  | out_valid / out_ready | out_byte, is_terminator, out_length
//  config  | cfg_wr_en             | cfg_index, cfg_data
//
//  the front takes one item a cycle while the four-entry command queue has room
//  back end: a command is popped in IDLE and run in EXEC; an ascii or '?' byte leaves from ONE,
//  the terminator from TERM, a table hit from TWO and LO after the search; each probe uses the
//  single read port of the table ram: read in SEARCH, compare in CMP; a miss ends on an empty range
//  reset clears decoder, queue, counters and output; the table ram holds garbage until loaded
//  a stalled output holds the back end, the queue then fills and in_ready drops
module utf8_to_gb2312_transcoder
    import u2gb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [7:0]            text_byte,
    input  logic [SLOT_W-1:0]     entry_slot,
    input  logic [CODE_W-1:0]     entry_code_point,
    input  logic [CODE_W-1:0]     entry_gb_code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  is_terminator,
    output logic [CAPACITY_W-1:0] out_length
);

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t pop_cmd;
    logic empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_entries   <= ENTRIES_RESET;
            cfg_reg.output_capacity <= CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TABLE_ENTRIES:   cfg_reg.table_entries   <= cfg_data[ENTRIES_W-1:0];
                REG_OUTPUT_CAPACITY: cfg_reg.output_capacity <= cfg_data[CAPACITY_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    u2gb_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .text_byte        (text_byte),
        .entry_slot       (entry_slot),
        .entry_code_point (entry_code_point),
        .entry_gb_code    (entry_gb_code),
        .full             (full),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    u2gb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    u2gb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .empty         (empty),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .out_length    (out_length)
    );

endmodule
